>>> rtl/ssr_pkg.sv
// Shared types and constants for the stream string replace block.
// No dependencies; imported by every module of the block.
package ssr_pkg;

    // APB register map: 64-bit registers at byte address 8*index
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    typedef struct packed {
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_length;
        logic [63:0] replacement_bytes;
        logic [3:0]  replacement_length;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // append input byte to the window
        logic shift_emit;  // emit oldest held byte and shift the window
        logic rep_emit;    // emit next replacement byte
        logic nl_emit;     // emit newline
        logic clear_count; // drop the window after a match
        logic rep_reset;   // restart the replacement index
        logic last;        // last flag of the emitted beat
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;         // output register can take a beat
        logic count_zero;       // window empty
        logic match;            // window equals the full pattern
        logic need_shift;       // window is not a proper prefix
        logic need_shift_after; // same test on the window minus its oldest byte
        logic rep_last;         // replacement index at final byte
        logic rep_empty;        // replacement length is zero
    } status_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EVAL  = 6'b000010,
        ST_SHIFT = 6'b000100,
        ST_REPL  = 6'b001000,
        ST_FLUSH = 6'b010000,
        ST_NL    = 6'b100000
    } state_t;

endpackage

>>> rtl/stream_string_replace.sv
// Stream string replace: top level joining config, controller and datapath.
// Depends on ssr_pkg, ssr_config, ssr_ctrl and ssr_datapath.
//
// Usage:
//   Input stream: s_tdata[7:0] is a text byte, s_tlast marks a line end (the
//   byte is then ignored). Output stream: m_tdata[7:0] is a rewritten byte,
//   m_tlast marks the final beat caused by one input beat.
//   Configure over APB (64-bit registers at byte addresses 0, 8, 16, 24:
//   pattern bytes, pattern length, replacement bytes, replacement length)
//   only while the stream is idle.
//   Steps: a text beat is accepted, then evaluated, then 0 to 8 output beats
//   follow. A line end is accepted, each held byte is emitted, the controller
//   turns to the newline state and then emits the newline. The controller
//   handles one item at a time and the single output register sets one beat
//   per cycle at most. A stalled receiver holds the output register and
//   stops the controller in its emitting states until the beat is taken;
//   s_tready is high only while the controller is idle.
//   Reset clears the configuration registers to zero, empties the held window and drops
//   any pending output beat.
module stream_string_replace
    import ssr_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES     = 8,
    parameter int MAX_REPLACEMENT_BYTES = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] char_byte
    input  logic                  s_tlast,   // line_end
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic                  m_tlast,   // last_of_run
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    ssr_config u_config (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    ssr_datapath #(
        .MAX_PATTERN_BYTES     (MAX_PATTERN_BYTES),
        .MAX_REPLACEMENT_BYTES (MAX_REPLACEMENT_BYTES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_byte  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/ssr_config.sv
// APB configuration registers for the stream string replace block.
// Depends on ssr_pkg for the register map and the cfg_t bundle.
module ssr_config
    import ssr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:3];
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_PATTERN_BYTES:      cfg_next.pattern_bytes      = pwdata;
                REG_PATTERN_LENGTH:     cfg_next.pattern_length     = pwdata[3:0];
                REG_REPLACEMENT_BYTES:  cfg_next.replacement_bytes  = pwdata;
                REG_REPLACEMENT_LENGTH: cfg_next.replacement_length = pwdata[3:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        case (reg_index)
            REG_PATTERN_BYTES:      prdata = cfg_reg.pattern_bytes;
            REG_PATTERN_LENGTH:     prdata = {60'd0, cfg_reg.pattern_length};
            REG_REPLACEMENT_BYTES:  prdata = cfg_reg.replacement_bytes;
            REG_REPLACEMENT_LENGTH: prdata = {60'd0, cfg_reg.replacement_length};
            default:                prdata = '0;
        endcase
    end

endmodule

>>> rtl/ssr_datapath.sv
// Datapath: held window, prefix compare, replacement index and output register.
// Depends on ssr_pkg; driven by ssr_ctrl through cmd_t and reports in status_t.
module ssr_datapath
    import ssr_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES     = 8,
    parameter int MAX_REPLACEMENT_BYTES = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic [7:0] in_byte,
    input  cmd_t       cmd,
    output status_t    status,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    localparam int D     = MAX_PATTERN_BYTES;
    localparam int CNT_W = $clog2(D + 1);
    localparam int IDX_W = (D > 1) ? $clog2(D) : 1;
    localparam int R_W   = (MAX_REPLACEMENT_BYTES > 1) ? $clog2(MAX_REPLACEMENT_BYTES) : 1;
    localparam logic [3:0] PMAX = 4'(MAX_PATTERN_BYTES);
    localparam logic [3:0] RMAX = 4'(MAX_REPLACEMENT_BYTES);

    logic [7:0]       window_reg [D];
    logic [7:0]       window_next [D];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_after;
    logic [R_W-1:0]   rep_idx_reg;
    logic [R_W-1:0]   rep_idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_byte_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic [3:0] plen;
    logic [3:0] rlen;
    logic       prefix_now;
    logic       prefix_after;
    logic       out_free;
    logic       emit;

    // Clamp configured lengths
    assign plen = (cfg.pattern_length > PMAX) ? PMAX : cfg.pattern_length;
    assign rlen = (cfg.replacement_length > RMAX) ? RMAX : cfg.replacement_length;

    assign count_after = count_reg - CNT_W'(1);

    // Compare the window, and the window without its oldest byte, against the pattern
    always_comb
    begin
        prefix_now   = 1'b1;
        prefix_after = 1'b1;
        for (int i = 0; i < D; i++)
        begin
            if (count_reg > CNT_W'(i) && window_reg[i] != cfg.pattern_bytes[8*i +: 8])
                prefix_now = 1'b0;
        end
        for (int i = 0; i < D - 1; i++)
        begin
            if (count_after > CNT_W'(i) && window_reg[i+1] != cfg.pattern_bytes[8*i +: 8])
                prefix_after = 1'b0;
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        status.out_free         = out_free;
        status.count_zero       = (count_reg == '0);
        status.match            = (plen != 4'd0) && (4'(count_reg) == plen) && prefix_now;
        status.need_shift       = (count_reg != '0)
                                  && ((4'(count_reg) >= plen) || !prefix_now);
        status.need_shift_after = (count_after != '0)
                                  && ((4'(count_after) >= plen) || !prefix_after);
        status.rep_last         = (4'(rep_idx_reg) == rlen - 4'd1);
        status.rep_empty        = (rlen == 4'd0);
    end

    // Window and count
    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        if (cmd.clear_count)
        begin
            count_next = '0;
        end
        else if (cmd.shift_emit)
        begin
            for (int i = 0; i < D - 1; i++)
                window_next[i] = window_reg[i+1];
            count_next = count_after;
        end
        else if (cmd.load && count_reg < CNT_W'(D))
        begin
            window_next[count_reg[IDX_W-1:0]] = in_byte;
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Replacement index
    always_comb
    begin
        rep_idx_next = rep_idx_reg;
        if (cmd.rep_reset)
            rep_idx_next = '0;
        else if (cmd.rep_emit)
            rep_idx_next = rep_idx_reg + R_W'(1);
    end

    // Output register: load a beat or drain the taken one
    assign emit = cmd.shift_emit || cmd.rep_emit || cmd.nl_emit;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_last_next  = cmd.last;
            if (cmd.shift_emit)
                out_byte_next = window_reg[0];
            else if (cmd.rep_emit)
                out_byte_next = cfg.replacement_bytes[{rep_idx_reg, 3'b000} +: 8];
            else
                out_byte_next = NEWLINE_BYTE;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rep_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rep_idx_reg   <= rep_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        window_reg   <= window_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(D))
        else $error("held count above window depth");

    a_clear_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_count |=> count_reg == '0)
        else $error("window not cleared after match");

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("beat emitted into a full output register");
`endif

endmodule

>>> rtl/ssr_ctrl.sv
// Controller state machine for the stream string replace block.
// Depends on ssr_pkg; sequences ssr_datapath through cmd_t / status_t.
module ssr_ctrl
    import ssr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  logic    s_tlast,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tlast)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                if (status.match)
                begin
                    cmd.clear_count = 1'b1;
                    cmd.rep_reset   = 1'b1;
                    state_next      = status.rep_empty ? ST_IDLE : ST_REPL;
                end
                else if (status.need_shift)
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                if (status.out_free)
                begin
                    cmd.shift_emit = 1'b1;
                    cmd.last       = !status.need_shift_after;
                    if (!status.need_shift_after)
                        state_next = ST_IDLE;
                end
            end
            ST_REPL:
            begin
                if (status.out_free)
                begin
                    cmd.rep_emit = 1'b1;
                    cmd.last     = status.rep_last;
                    if (status.rep_last)
                        state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (status.count_zero)
                begin
                    state_next = ST_NL;
                end
                else if (status.out_free)
                begin
                    cmd.shift_emit = 1'b1;
                end
            end
            ST_NL:
            begin
                if (status.out_free)
                begin
                    cmd.nl_emit = 1'b1;
                    cmd.last    = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTH
    a_byte_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tlast) |=> state_reg == ST_EVAL)
        else $error("text beat not followed by evaluation");

    a_shift_needed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> status.need_shift)
        else $error("shift state with a window that is already a prefix");
`endif

endmodule
